/* design/assert_macros.svh */
// Assertion macros used by the indexed list top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ilid_pkg.sv */
// Shared types, codes and constants for the indexed list block.
package ilid_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int CMD_W        = 3;
  localparam int ST_W         = 2;
  localparam int LEN_W        = 6;
  localparam int CAPACITY_DEF = 32;

  localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } ilid_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [ST_W-1:0]          status;
    logic [LEN_W-1:0]         list_length;
  } ilid_rsp_t;

  // Broadcast control seen by every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [DATA_W-1:0] value;
  } ilid_ctl_t;

endpackage

/* design/indexed_list_insert_delete.sv */
// Top level of the indexed list: a chain of entry cells with one result register.
// Each response word appears in the cycle after its request word is accepted.
// Throughput: one request word per cycle; all cells shift in the same cycle.
// A request is held off only while the response register is full and stalled.
// Reset (rst, synchronous, active high) empties the list and the response register.
// Cell contents are not reset; entries are only read after an insert wrote them.
module indexed_list_insert_delete #(
  parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ilid_pkg::ilid_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ilid_pkg::ilid_rsp_t rsp
);
  import ilid_pkg::*;
  `include "assert_macros.svh"

  // Count width holds CAPACITY itself; compares run at the wider of the
  // count and the position field so that no bit is lost either way.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = (CW > POS_W) ? CW : POS_W;
  localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              accept;
  logic [TW-1:0]     count_t;
  logic [TW-1:0]     pos_t;
  logic [TW-1:0]     tgt;
  logic              is_ins;
  logic              is_del;
  logic              is_read;
  logic              ins_ok;
  logic              del_ok;
  logic              read_ok;
  logic [ST_W-1:0]   status;
  logic [DATA_W-1:0] rd_or;
  ilid_ctl_t         ctl;
  ilid_rsp_t         rsp_next;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];

  // The response register is the only buffer: a new word may enter
  // whenever that register is empty or being drained this cycle.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign count_t = TW'(count);
  assign pos_t   = TW'(req.position);

  assign is_read = req.cmd == CMD_READ;
  assign is_del  = req.cmd == CMD_DELETE;
  assign is_ins  = (req.cmd == CMD_INS_POS) || (req.cmd == CMD_INS_HEAD) ||
                   (req.cmd == CMD_INS_TAIL);

  // Head and tail inserts are position inserts at zero and at the count.
  always_comb begin
    case (req.cmd)
      CMD_INS_HEAD: tgt = '0;
      CMD_INS_TAIL: tgt = count_t;
      default:      tgt = pos_t;
    endcase
  end

  assign read_ok = pos_t < count_t;
  assign del_ok  = is_del && (pos_t < count_t);
  assign ins_ok  = is_ins && (tgt <= count_t) && (count_t < CAP_T);

  // The range check of an insert comes before the full check.
  always_comb begin
    status = ST_DONE;
    if (is_read && !read_ok) begin
      status = ST_RANGE;
    end else if (is_del && !del_ok) begin
      status = ST_RANGE;
    end else if (is_ins && (tgt > count_t)) begin
      status = ST_RANGE;
    end else if (is_ins && (count_t >= CAP_T)) begin
      status = ST_FULL;
    end
  end

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = CW'(count + 1'b1);
    end else if (del_ok) begin
      count_next = CW'(count - 1'b1);
    end
  end

  assign ctl.ins   = accept && ins_ok;
  assign ctl.del   = accept && del_ok;
  assign ctl.value = req.value;

  // The chain: every cell sees its lower and upper neighbor. The ends
  // take inputs that are never selected in a way that matters.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ilid_cell #(
      .INDEX (i),
      .TW    (TW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .tgt     (tgt),
      .rd_pos  (pos_t),
      .left    ((i == 0) ? req.value : cell_data[(i == 0) ? 0 : i - 1]),
      .right   ((i == CAPACITY - 1) ? cell_data[i]
                                    : cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .data    (cell_data[i]),
      .rd_data (cell_rd[i])
    );
  end

  // At most one cell matches the read position, so an OR picks it out.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    rsp_next.read_value  = (is_read && read_ok) ? $signed(rd_or) : '1;
    rsp_next.status      = status;
    rsp_next.list_length = LEN_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // The list never holds more entries than there are cells; the count is
  // unknown until the first reset edge, so reset itself satisfies the check.
  `ASSERT_ALWAYS(a_count_bound, clk, rst || (count <= CW'(CAPACITY)), "entry count above capacity")
  // Every accepted word yields a response in the next cycle.
  `ASSERT_CLK(a_rsp_follows, clk, rst, accept |=> rsp_valid, "response missing after accept")
  // The count changes only when a word is accepted.
  `ASSERT_CLK(a_count_hold, clk, rst, !accept |=> $stable(count), "count moved without accept")
  // A full report always stands beside a full list.
  `ASSERT_CLK(a_full_len, clk, rst,
              (rsp_valid && rsp.status == ST_FULL) |-> (count == CW'(CAPACITY)),
              "full status with list not full")

endmodule

/* design/ilid_cell.sv */
// One entry cell of the list chain: holds a value and shifts with its neighbors.
module ilid_cell #(
  parameter int INDEX = 0,
  parameter int TW    = 6
) (
  input  logic                      clk,
  input  ilid_pkg::ilid_ctl_t       ctl,
  input  logic [TW-1:0]             tgt,
  input  logic [TW-1:0]             rd_pos,
  input  logic [ilid_pkg::DATA_W-1:0] left,
  input  logic [ilid_pkg::DATA_W-1:0] right,
  output logic [ilid_pkg::DATA_W-1:0] data,
  output logic [ilid_pkg::DATA_W-1:0] rd_data
);
  import ilid_pkg::*;

  localparam logic [TW-1:0] IDX = TW'(INDEX);

  logic above;
  logic at;

  assign above = IDX > tgt;
  assign at    = IDX == tgt;

  // An insert moves later entries up and drops the new value in place;
  // a delete pulls the target and later entries down by one.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (above) begin
        data <= left;
      end else if (at) begin
        data <= ctl.value;
      end
    end else if (ctl.del) begin
      if (above || at) begin
        data <= right;
      end
    end
  end

  assign rd_data = (IDX == rd_pos) ? data : '0;

endmodule
